// ----- sv/tbn_pkg.sv -----
// Package for the triangle tangent basis block: payload types, datapath
// command/status structs and operation codes. No dependencies.
package tbn_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               last_corner;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
    logic               degenerate;
    logic               second_triangle;
  } out_item_t;

  localparam logic [4:0] OP_IDLE   = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;
  localparam logic [4:0] OP_DIFF   = 5'd2;
  localparam logic [4:0] OP_MUL    = 5'd3;
  localparam logic [4:0] OP_ACC    = 5'd4;
  localparam logic [4:0] OP_SIGN   = 5'd5;
  localparam logic [4:0] OP_MAG    = 5'd6;
  localparam logic [4:0] OP_SHR    = 5'd7;
  localparam logic [4:0] OP_SQ     = 5'd8;
  localparam logic [4:0] OP_ADDSQ  = 5'd9;
  localparam logic [4:0] OP_SQRT   = 5'd10;
  localparam logic [4:0] OP_NORM   = 5'd11;
  localparam logic [4:0] OP_DIV    = 5'd12;
  localparam logic [4:0] OP_STQ    = 5'd13;
  localparam logic [4:0] OP_CROSS  = 5'd14;
  localparam logic [4:0] OP_CROSSD = 5'd15;
  localparam logic [4:0] OP_DOTM   = 5'd16;
  localparam logic [4:0] OP_DOT    = 5'd17;
  localparam logic [4:0] OP_OUT    = 5'd18;

  localparam logic IT_SQRT = 1'b0;
  localparam logic IT_DIV  = 1'b1;

  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'd15;

  localparam logic signed [32:0] ONE_Q16 = 33'sd65536;
  localparam logic [31:0] TEX_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] idx;
    logic       vsel;
    logic [1:0] slot;
    logic       nwr;
    logic       nslot;
    logic       second;
  } dp_cmd_t;

  typedef struct packed {
    logic degen;
    logic big;
    logic busy;
  } dp_stat_t;

endpackage

// ----- sv/triangle_tangent_basis.sv -----
// Top level of the triangle tangent basis block: controller plus datapath.
// Depends on tbn_pkg, tbn_ctrl, tbn_datapath.
//
//  port group | handshake            | payload
//  in_        | in_valid / in_stall  | in_data  (tbn_pkg::in_item_t)
//  out_       | out_valid / out_stall| out_data (tbn_pkg::out_item_t)
//  cfg_       | cfg_valid / cfg_ready| cfg_data (tangents_enable)
//
// A corner that completes no triangle, or any corner while disabled, is taken at once.
// A corner that completes a triangle holds the input until its result enters the output
// register, including any wait for that register. A degenerate triangle goes straight
// to the output; otherwise the shared square root/divide unit (2 x 32 root steps
// + 6 x 15 divide steps) and the per-vector shift loop into 30 bits set the time.
// Reset is synchronous: corner count cleared, tangents enabled.
// A stalled result waits in the output register; new corners are taken until the
// next result needs the register.
module triangle_tangent_basis (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tbn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tbn_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  tbn_pkg::dp_cmd_t  cmd;
  tbn_pkg::dp_stat_t stat;

  tbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_corner),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd)
  );

  tbn_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> in_stall)
    else $error("root/divide unit busy while input open");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |->
      (out_data.tangent_x == 16'sd0 && out_data.tangent_y == 16'sd0 &&
       out_data.tangent_z == 16'sd0 && out_data.bitangent_x == 16'sd0 &&
       out_data.bitangent_y == 16'sd0 && out_data.bitangent_z == 16'sd0))
    else $error("degenerate transfer with nonzero vectors");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.tangent_x <= 16'sd16384 && out_data.tangent_x >= -16'sd16384 &&
       out_data.bitangent_x <= 16'sd16384 && out_data.bitangent_x >= -16'sd16384))
    else $error("unit vector component out of range");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tbn_pkg::OP_LOAD) |-> (in_valid && !in_stall))
    else $error("corner captured without a transfer");

endmodule

// ----- sv/tbn_iter_unit.sv -----
// Shared iterative unit: integer square root (two bits a step) and
// restoring division (one quotient bit a step). Uses tbn_pkg.
module tbn_iter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        op,
  input  logic [63:0] a,
  input  logic [32:0] b,
  output logic        busy,
  output logic [31:0] res
);

  logic [63:0] v_r, v_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic        op_r, op_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] trial;
  logic        ge;

  assign trial = (op_r == tbn_pkg::IT_SQRT) ? res_r + bit_r : bit_r;
  assign ge    = v_r >= trial;

  always_comb begin
    v_nxt   = v_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    op_nxt  = op_r;
    cnt_nxt = cnt_r;
    if (start) begin
      v_nxt   = a;
      res_nxt = '0;
      op_nxt  = op;
      if (op == tbn_pkg::IT_SQRT) begin
        bit_nxt = 64'h4000_0000_0000_0000;
        cnt_nxt = tbn_pkg::SQRT_STEPS;
      end else begin
        bit_nxt = {17'b0, b, 14'b0};
        cnt_nxt = tbn_pkg::DIV_STEPS;
      end
    end else if (cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (ge) v_nxt = v_r - trial;
      if (op_r == tbn_pkg::IT_SQRT) begin
        res_nxt = ge ? (res_r >> 1) + bit_r : res_r >> 1;
        bit_nxt = bit_r >> 2;
      end else begin
        res_nxt = {res_r[62:0], ge};
        bit_nxt = bit_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    op_r  <= op_nxt;
  end

  assign busy = cnt_r != 6'd0;
  assign res  = res_r[31:0];

endmodule

// ----- sv/tbn_ctrl.sv -----
// Controller: corner counting, configuration register, step sequencing
// and output valid. Uses tbn_pkg.
module tbn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  tbn_pkg::dp_stat_t  stat,
  output tbn_pkg::dp_cmd_t   cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DIFF   = 5'd1;
  localparam logic [4:0] S_MUL    = 5'd2;
  localparam logic [4:0] S_ACC    = 5'd3;
  localparam logic [4:0] S_SIGN   = 5'd4;
  localparam logic [4:0] S_MAG    = 5'd5;
  localparam logic [4:0] S_SHR    = 5'd6;
  localparam logic [4:0] S_SQ     = 5'd7;
  localparam logic [4:0] S_ADDSQ  = 5'd8;
  localparam logic [4:0] S_SQRT   = 5'd9;
  localparam logic [4:0] S_SQRTW  = 5'd10;
  localparam logic [4:0] S_NORM   = 5'd11;
  localparam logic [4:0] S_DIV    = 5'd12;
  localparam logic [4:0] S_DIVW   = 5'd13;
  localparam logic [4:0] S_STQ    = 5'd14;
  localparam logic [4:0] S_CROSS  = 5'd15;
  localparam logic [4:0] S_CROSSD = 5'd16;
  localparam logic [4:0] S_DOTM   = 5'd17;
  localparam logic [4:0] S_DOT    = 5'd18;
  localparam logic [4:0] S_OUT    = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       vsel_r, vsel_nxt;
  logic       second_r, second_nxt;
  logic       enable_r, enable_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       trig;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    vsel_nxt   = vsel_r;
    second_nxt = second_r;
    enable_nxt = cfg_valid ? cfg_data : enable_r;
    ovalid_nxt = ovalid_r && out_stall;
    trig       = 1'b0;
    cmd        = '0;
    cmd.op     = tbn_pkg::OP_IDLE;
    cmd.idx    = idx_r;
    cmd.vsel   = vsel_r;
    cmd.second = second_r;
    cmd.slot   = (cnt_r == 2'd3) ? 2'd1 : cnt_r;
    cmd.nslot  = cnt_r[1];
    cmd.nwr    = (cnt_r == 2'd0) || (cnt_r == 2'd2);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = tbn_pkg::OP_LOAD;
          case (cnt_r)
            2'd2: begin
              cnt_nxt    = in_last ? 2'd0 : 2'd3;
              trig       = 1'b1;
              second_nxt = 1'b0;
            end
            2'd3: begin
              cnt_nxt    = 2'd0;
              trig       = 1'b1;
              second_nxt = 1'b1;
            end
            default: begin
              cnt_nxt = in_last ? 2'd0 : cnt_r + 2'd1;
            end
          endcase
          if (trig && enable_r) state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.op    = tbn_pkg::OP_DIFF;
        idx_nxt   = 3'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = tbn_pkg::OP_MUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = tbn_pkg::OP_ACC;
        if (idx_r == 3'd6) begin
          state_nxt = S_SIGN;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_MUL;
        end
      end
      S_SIGN: begin
        cmd.op   = tbn_pkg::OP_SIGN;
        vsel_nxt = 1'b0;
        state_nxt = stat.degen ? S_OUT : S_MAG;
      end
      S_MAG: begin
        cmd.op    = tbn_pkg::OP_MAG;
        state_nxt = S_SHR;
      end
      S_SHR: begin
        if (stat.big) begin
          cmd.op = tbn_pkg::OP_SHR;
        end else begin
          idx_nxt   = 3'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op    = tbn_pkg::OP_SQ;
        state_nxt = S_ADDSQ;
      end
      S_ADDSQ: begin
        cmd.op = tbn_pkg::OP_ADDSQ;
        if (idx_r == 3'd2) begin
          state_nxt = S_SQRT;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_SQ;
        end
      end
      S_SQRT: begin
        cmd.op    = tbn_pkg::OP_SQRT;
        state_nxt = S_SQRTW;
      end
      S_SQRTW: begin
        if (!stat.busy) state_nxt = S_NORM;
      end
      S_NORM: begin
        cmd.op    = tbn_pkg::OP_NORM;
        idx_nxt   = 3'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op    = tbn_pkg::OP_DIV;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (!stat.busy) state_nxt = S_STQ;
      end
      S_STQ: begin
        cmd.op = tbn_pkg::OP_STQ;
        if (idx_r != 3'd2) begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_DIV;
        end else if (vsel_r) begin
          state_nxt = S_CROSS;
        end else begin
          vsel_nxt  = 1'b1;
          state_nxt = S_MAG;
        end
      end
      S_CROSS: begin
        cmd.op    = tbn_pkg::OP_CROSS;
        state_nxt = S_CROSSD;
      end
      S_CROSSD: begin
        cmd.op    = tbn_pkg::OP_CROSSD;
        state_nxt = S_DOTM;
      end
      S_DOTM: begin
        cmd.op    = tbn_pkg::OP_DOTM;
        state_nxt = S_DOT;
      end
      S_DOT: begin
        cmd.op    = tbn_pkg::OP_DOT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_r || !out_stall) begin
          cmd.op     = tbn_pkg::OP_OUT;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      idx_r    <= '0;
      vsel_r   <= 1'b0;
      second_r <= 1'b0;
      enable_r <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      vsel_r   <= vsel_nxt;
      second_r <= second_nxt;
      enable_r <= enable_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = ovalid_r;
  assign cfg_ready = 1'b1;

endmodule

// ----- sv/tbn_datapath.sv -----
// Datapath: corner store, edge/UV products, normalisation, handedness
// and output register. Uses tbn_pkg and tbn_iter_unit.
module tbn_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tbn_pkg::in_item_t   in_data,
  input  tbn_pkg::dp_cmd_t    cmd,
  output tbn_pkg::dp_stat_t   stat,
  output tbn_pkg::out_item_t  out_data
);

  logic signed [31:0] pos_r [0:2][0:2];
  logic signed [31:0] tu_r  [0:2];
  logic signed [31:0] tv_r  [0:2];
  logic signed [15:0] nrm_r [0:1][0:2];
  logic signed [32:0] e1_r [0:2];
  logic signed [32:0] e2_r [0:2];
  logic signed [32:0] du1_r, dv1_r, du2_r, dv2_r;
  logic signed [65:0] pa_r, pb_r;
  logic signed [66:0] acc_r [0:6];
  logic               neg_r [0:2];
  logic [65:0]        mag_r [0:2];
  logic [59:0]        sq_r;
  logic [61:0]        sum_r;
  logic [31:0]        norm_r;
  logic signed [15:0] tvec_r [0:2];
  logic signed [15:0] bvec_r [0:2];
  logic               deg_r;
  logic signed [31:0] cp_r [0:5];
  logic signed [32:0] cr_r [0:2];
  logic signed [48:0] cn_r [0:2];
  tbn_pkg::out_item_t out_r;

  logic signed [32:0] fv;
  logic signed [32:0] ma, mb, mc, md;
  logic signed [50:0] dot;
  logic [29:0]        sq_op;
  logic [29:0]        div_op;
  logic [63:0]        it_a;
  logic               it_start, it_op, it_busy;
  logic [31:0]        it_res;
  logic signed [15:0] qs;
  logic               t_zero, b_zero;

  assign fv = tbn_pkg::ONE_Q16 - 33'(in_data.tex_v);

  always_comb begin
    case (cmd.idx)
      3'd0: begin ma = du1_r; mb = dv2_r;   mc = du2_r; md = dv1_r;   end
      3'd1: begin ma = dv2_r; mb = e1_r[0]; mc = dv1_r; md = e2_r[0]; end
      3'd2: begin ma = dv2_r; mb = e1_r[1]; mc = dv1_r; md = e2_r[1]; end
      3'd3: begin ma = dv2_r; mb = e1_r[2]; mc = dv1_r; md = e2_r[2]; end
      3'd4: begin ma = du1_r; mb = e2_r[0]; mc = du2_r; md = e1_r[0]; end
      3'd5: begin ma = du1_r; mb = e2_r[1]; mc = du2_r; md = e1_r[1]; end
      3'd6: begin ma = du1_r; mb = e2_r[2]; mc = du2_r; md = e1_r[2]; end
      default: begin ma = '0; mb = '0; mc = '0; md = '0; end
    endcase
    case (cmd.idx)
      3'd0:    begin sq_op = mag_r[0][29:0]; end
      3'd1:    begin sq_op = mag_r[1][29:0]; end
      default: begin sq_op = mag_r[2][29:0]; end
    endcase
    div_op = sq_op;
  end

  assign t_zero = (acc_r[1] == '0) && (acc_r[2] == '0) && (acc_r[3] == '0);
  assign b_zero = (acc_r[4] == '0) && (acc_r[5] == '0) && (acc_r[6] == '0);
  assign stat.degen = (acc_r[0] == '0) || t_zero || b_zero;
  assign stat.big = (mag_r[0][65:30] != '0) || (mag_r[1][65:30] != '0) ||
                    (mag_r[2][65:30] != '0);
  assign stat.busy = it_busy;

  assign it_start = (cmd.op == tbn_pkg::OP_SQRT) || (cmd.op == tbn_pkg::OP_DIV);
  assign it_op    = (cmd.op == tbn_pkg::OP_DIV) ? tbn_pkg::IT_DIV : tbn_pkg::IT_SQRT;
  assign it_a     = (cmd.op == tbn_pkg::OP_DIV) ?
                    {19'b0, div_op, 15'b0} + {32'b0, norm_r} : {2'b0, sum_r};
  assign qs  = {1'b0, it_res[14:0]};
  assign dot = 51'(cn_r[0]) + 51'(cn_r[1]) + 51'(cn_r[2]);

  tbn_iter_unit u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .start (it_start),
    .op    (it_op),
    .a     (it_a),
    .b     ({norm_r, 1'b0}),
    .busy  (it_busy),
    .res   (it_res)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      tbn_pkg::OP_LOAD: begin
        pos_r[cmd.slot][0] <= in_data.pos_x;
        pos_r[cmd.slot][1] <= in_data.pos_y;
        pos_r[cmd.slot][2] <= in_data.pos_z;
        tu_r[cmd.slot]     <= in_data.tex_u;
        tv_r[cmd.slot]     <= (!fv[32] && fv[31]) ? tbn_pkg::TEX_MAX : fv[31:0];
        if (cmd.nwr) begin
          nrm_r[cmd.nslot][0] <= in_data.norm_x;
          nrm_r[cmd.nslot][1] <= in_data.norm_y;
          nrm_r[cmd.nslot][2] <= in_data.norm_z;
        end
      end
      tbn_pkg::OP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          if (cmd.second) begin
            e1_r[k] <= 33'(pos_r[1][k]) - 33'(pos_r[2][k]);
            e2_r[k] <= 33'(pos_r[0][k]) - 33'(pos_r[2][k]);
          end else begin
            e1_r[k] <= 33'(pos_r[1][k]) - 33'(pos_r[0][k]);
            e2_r[k] <= 33'(pos_r[2][k]) - 33'(pos_r[0][k]);
          end
        end
        if (cmd.second) begin
          du1_r <= 33'(tu_r[1]) - 33'(tu_r[2]);
          dv1_r <= 33'(tv_r[1]) - 33'(tv_r[2]);
          du2_r <= 33'(tu_r[0]) - 33'(tu_r[2]);
          dv2_r <= 33'(tv_r[0]) - 33'(tv_r[2]);
        end else begin
          du1_r <= 33'(tu_r[1]) - 33'(tu_r[0]);
          dv1_r <= 33'(tv_r[1]) - 33'(tv_r[0]);
          du2_r <= 33'(tu_r[2]) - 33'(tu_r[0]);
          dv2_r <= 33'(tv_r[2]) - 33'(tv_r[0]);
        end
      end
      tbn_pkg::OP_MUL: begin
        pa_r <= 66'(ma) * 66'(mb);
        pb_r <= 66'(mc) * 66'(md);
      end
      tbn_pkg::OP_ACC: begin
        acc_r[cmd.idx] <= 67'(pa_r) - 67'(pb_r);
      end
      tbn_pkg::OP_SIGN: begin
        deg_r <= stat.degen;
        if (stat.degen) begin
          for (int k = 0; k < 3; k++) begin
            tvec_r[k] <= '0;
            bvec_r[k] <= '0;
          end
        end else if (acc_r[0][66]) begin
          for (int k = 1; k < 7; k++) acc_r[k] <= -acc_r[k];
        end
      end
      tbn_pkg::OP_MAG: begin
        for (int k = 0; k < 3; k++) begin
          if (cmd.vsel) begin
            neg_r[k] <= acc_r[k + 4][66];
            mag_r[k] <= acc_r[k + 4][66] ? 66'(-acc_r[k + 4]) : acc_r[k + 4][65:0];
          end else begin
            neg_r[k] <= acc_r[k + 1][66];
            mag_r[k] <= acc_r[k + 1][66] ? 66'(-acc_r[k + 1]) : acc_r[k + 1][65:0];
          end
        end
        sum_r <= '0;
      end
      tbn_pkg::OP_SHR: begin
        for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
      end
      tbn_pkg::OP_SQ: begin
        sq_r <= 60'(sq_op) * 60'(sq_op);
      end
      tbn_pkg::OP_ADDSQ: begin
        sum_r <= sum_r + 62'(sq_r);
      end
      tbn_pkg::OP_NORM: begin
        norm_r <= (it_res == '0) ? 32'd1 : it_res;
      end
      tbn_pkg::OP_STQ: begin
        if (cmd.vsel) begin
          bvec_r[cmd.idx[1:0]] <= neg_r[cmd.idx[1:0]] ? -qs : qs;
        end else begin
          tvec_r[cmd.idx[1:0]] <= neg_r[cmd.idx[1:0]] ? -qs : qs;
        end
      end
      tbn_pkg::OP_CROSS: begin
        cp_r[0] <= 32'(tvec_r[1]) * 32'(bvec_r[2]);
        cp_r[1] <= 32'(tvec_r[2]) * 32'(bvec_r[1]);
        cp_r[2] <= 32'(tvec_r[2]) * 32'(bvec_r[0]);
        cp_r[3] <= 32'(tvec_r[0]) * 32'(bvec_r[2]);
        cp_r[4] <= 32'(tvec_r[0]) * 32'(bvec_r[1]);
        cp_r[5] <= 32'(tvec_r[1]) * 32'(bvec_r[0]);
      end
      tbn_pkg::OP_CROSSD: begin
        cr_r[0] <= 33'(cp_r[0]) - 33'(cp_r[1]);
        cr_r[1] <= 33'(cp_r[2]) - 33'(cp_r[3]);
        cr_r[2] <= 33'(cp_r[4]) - 33'(cp_r[5]);
      end
      tbn_pkg::OP_DOTM: begin
        for (int k = 0; k < 3; k++) begin
          cn_r[k] <= 49'(cr_r[k]) * 49'(cmd.second ? nrm_r[1][k] : nrm_r[0][k]);
        end
      end
      tbn_pkg::OP_DOT: begin
        if (dot[50]) begin
          for (int k = 0; k < 3; k++) tvec_r[k] <= -tvec_r[k];
        end
      end
      tbn_pkg::OP_OUT: begin
        out_r.tangent_x       <= tvec_r[0];
        out_r.tangent_y       <= tvec_r[1];
        out_r.tangent_z       <= tvec_r[2];
        out_r.bitangent_x     <= bvec_r[0];
        out_r.bitangent_y     <= bvec_r[1];
        out_r.bitangent_z     <= bvec_r[2];
        out_r.degenerate      <= deg_r;
        out_r.second_triangle <= cmd.second;
      end
      default: begin
      end
    endcase
  end

  assign out_data = out_r;

endmodule
